// ===== rtl/sst_pkg.sv =====
// Shared types and codes for the sorted set table.
package sst_pkg;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

endpackage

// ===== rtl/sst_if.sv =====
// Request and response channel interfaces of the sorted set table.
interface sst_req_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface sst_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [COUNT_WIDTH-1:0]        entry_count;
  logic signed [VALUE_WIDTH-1:0] smallest;
  logic signed [VALUE_WIDTH-1:0] largest;

  modport source (output valid, status, entry_count, smallest, largest, input ready);
  modport sink   (input valid, status, entry_count, smallest, largest, output ready);
endinterface

// ===== rtl/sorted_set_table_top.sv =====
// Sorted set table: ascending set of distinct signed values with insert and remove.
//
// A request word on req carries an action (insert or remove) and a value. The
// table answers each request with one response word on rsp: a status (done,
// already present, not present, table full), the count after the operation,
// and the smallest and largest held values (zero when the table is empty).
// Values live in one single-port-write, registered-read memory; a small
// sequencer reuses one signed comparator and the memory port for every step.
// A request passes through: an accept step, a linear lower-bound scan that
// stops at the first entry not below the value (skipped when the table is
// empty), a decide step, a shift of the entries above that position (up for
// an insert, down for a remove), a write of the new value for an insert, and
// a read-back of the smallest and largest entries. A refused request skips
// the shift and the write.
// req.ready is high only while the sequencer is idle. The response sits in an
// output register; the next request is taken while it waits, and the
// sequencer holds at its last step until rsp.ready frees the register. Reset
// empties the table (count zero, no clearing pass) and drops any pending
// response.
module sorted_set_table_top
  import sst_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  sst_req_if.sink      req,
  sst_rsp_if.source    rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_UP, S_SHIFT_DN,
    S_WRITE_NEW, S_FETCH, S_FETCH_HI, S_FETCH_END
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           pos;
  action_t                 act;
  logic signed [VALUE_WIDTH-1:0] val;
  logic                    present;
  status_t                 status;
  logic signed [VALUE_WIDTH-1:0] lo;

  logic                    out_valid;
  status_t                 out_status;
  logic [CW-1:0]           out_count;
  logic signed [VALUE_WIDTH-1:0] out_smallest;
  logic signed [VALUE_WIDTH-1:0] out_largest;

  logic [VALUE_WIDTH-1:0]  mem [CAPACITY];
  logic [VALUE_WIDTH-1:0]  rd_data;
  logic [AW-1:0]           mem_ra;
  logic [AW-1:0]           mem_wa;
  logic [VALUE_WIDTH-1:0]  mem_wd;
  logic                    mem_we;

  logic [CW-1:0]           ptr_inc;
  logic [CW-1:0]           ptr_dec;
  logic [CW-1:0]           pos_inc;
  logic [CW-1:0]           count_dec;
  logic                    is_less;
  logic                    out_free;
  logic                    load_out;

  assign ptr_inc   = ptr + 1'b1;
  assign ptr_dec   = ptr - 1'b1;
  assign pos_inc   = pos + 1'b1;
  assign count_dec = count - 1'b1;
  assign is_less   = $signed(rd_data) < val;
  assign out_free  = !out_valid || rsp.ready;
  assign load_out  = (state == S_FETCH_END) && out_free;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_comb begin
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    case (state)
      S_SCAN:      mem_ra = ptr[AW-1:0];
      S_DECIDE: begin
        if (act == ACT_INSERT) mem_ra = count_dec[AW-1:0];
        else                   mem_ra = pos_inc[AW-1:0];
      end
      S_SHIFT_UP: begin
        mem_we = 1'b1;
        mem_wa = ptr_inc[AW-1:0];
        mem_ra = ptr_dec[AW-1:0];
      end
      S_SHIFT_DN: begin
        mem_we = 1'b1;
        mem_wa = ptr_dec[AW-1:0];
        mem_ra = ptr_inc[AW-1:0];
      end
      S_WRITE_NEW: begin
        mem_we = 1'b1;
        mem_wa = pos[AW-1:0];
        mem_wd = val;
      end
      S_FETCH_HI, S_FETCH_END: mem_ra = count_dec[AW-1:0];
      default:     mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act <= action_t'(req.action);
            val <= req.value;
            if (count == '0) begin
              pos     <= '0;
              present <= 1'b0;
              state   <= S_DECIDE;
            end else begin
              ptr   <= CW'(1);
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // rd_data holds the entry at ptr-1
          if (is_less) begin
            if (ptr == count) begin
              pos     <= count;
              present <= 1'b0;
              state   <= S_DECIDE;
            end else begin
              ptr <= ptr_inc;
            end
          end else begin
            pos     <= ptr_dec;
            present <= (rd_data == val);
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (act == ACT_INSERT) begin
            if (present) begin
              status <= ST_PRESENT;
              state  <= S_FETCH;
            end else if (count == CAP_C) begin
              status <= ST_FULL;
              state  <= S_FETCH;
            end else begin
              status <= ST_DONE;
              if (pos == count) begin
                state <= S_WRITE_NEW;
              end else begin
                ptr   <= count_dec;
                state <= S_SHIFT_UP;
              end
            end
          end else begin
            if (!present) begin
              status <= ST_ABSENT;
              state  <= S_FETCH;
            end else begin
              status <= ST_DONE;
              if (pos_inc == count) begin
                count <= count_dec;
                state <= S_FETCH;
              end else begin
                ptr   <= pos_inc;
                state <= S_SHIFT_DN;
              end
            end
          end
        end
        S_SHIFT_UP: begin
          if (ptr == pos) state <= S_WRITE_NEW;
          else            ptr   <= ptr_dec;
        end
        S_SHIFT_DN: begin
          if (ptr_inc == count) begin
            count <= count_dec;
            state <= S_FETCH;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_WRITE_NEW: begin
          count <= count + 1'b1;
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_FETCH_HI;
        end
        S_FETCH_HI: begin
          lo    <= rd_data;
          state <= S_FETCH_END;
        end
        S_FETCH_END: begin
          // hold until the response register is free
          if (out_free) begin
            out_status   <= status;
            out_count    <= count;
            out_smallest <= (count == '0) ? '0 : lo;
            out_largest  <= (count == '0) ? '0 : rd_data;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;
  assign rsp.smallest    = out_smallest;
  assign rsp.largest     = out_largest;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("held count exceeds capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count == '0) |-> (out_smallest == '0 && out_largest == '0))
    else $error("empty table reports nonzero bounds");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_count != '0) |-> (out_smallest <= out_largest))
    else $error("smallest above largest");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FULL) |-> (out_count == CAP_C))
    else $error("full status with room left");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("sequencer idle right after accept");

endmodule
